// ===== rtl/spmf_pkg.sv =====
// ============================================================================
// spmf_pkg - shared types and constants of the strict-priority multi-FIFO
// Words of the command and response channels, per-level control and status,
// status codes and parameter defaults.
// ============================================================================
package spmf_pkg;

    // parameter defaults
    localparam int LEVEL_COUNT_DEF  = 8;
    localparam int LEVEL_DEPTH_DEF  = 16;
    localparam int HANDLE_WIDTH_DEF = 32;

    // fixed field widths
    localparam int ITEM_W  = 32;
    localparam int PRIO_W  = 3;
    localparam int CFG_W   = 4;
    localparam int COUNT_W = 8;

    localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd8;

    typedef enum logic
    {
        FUNC_ENQ,
        FUNC_DEQ
    } func_t;

    typedef enum logic [1:0]
    {
        ST_OK,
        ST_RANGE,
        ST_EMPTY,
        ST_FULL
    } status_t;

    typedef struct packed
    {
        func_t              func;
        logic [ITEM_W-1:0]  item;
        logic [PRIO_W-1:0]  priority_req;
    } cmd_word_t;

    typedef struct packed
    {
        logic [ITEM_W-1:0]  result_item;
        logic               result_valid;
        status_t            status;
        logic [ITEM_W-1:0]  front_item;
        logic               front_valid;
        logic               is_empty;
        logic [COUNT_W-1:0] item_count;
    } rsp_word_t;

    // per-level control from the top level
    typedef struct packed
    {
        logic push;
        logic pop;
    } lvl_ctrl_t;

    // per-level status back to the top level
    typedef struct packed
    {
        logic nonempty;
        logic full;
        logic nonempty_next;
    } lvl_stat_t;

endpackage

// ===== rtl/spmf_stream_if.sv =====
// ============================================================================
// spmf_stream_if - valid/ready channel carrying one word
// The word type is set per instance.
// ============================================================================
interface spmf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source
    (
        output valid,
        output payload,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ===== rtl/strict_priority_multi_fifo.sv =====
// ============================================================================
// strict_priority_multi_fifo - strict-priority queue of per-level FIFOs
// Enqueue stores a handle at its priority level; dequeue removes the oldest
// handle of the highest non-empty level. Every command returns one response
// word with status, front item, empty flag and total count.
// ============================================================================
//
//   channel | dir | handshake        | word
//   --------+-----+------------------+---------------------------------------
//   cmd     | in  | valid/ready      | func, item, priority_req
//   rsp     | out | valid/ready      | result_item/valid, status, front, count
//   cfg     | in  | cfg_wr_en pulse  | levels_in_use (4 bits), no read-back
//
// One command per cycle sustained while rsp is not stalled; a command passes
// through the command register, then the response register. Level selection
// is a priority encoder over the per-level non-empty bits, and each level keeps
// its front word and the word behind it in registers, so back-to-back dequeues
// need no memory wait. Reset empties every level and sets levels_in_use to 8;
// no clearing pass. A stalled rsp holds its word; cmd keeps taking words until
// the command register is also full.
//
module strict_priority_multi_fifo #(
    parameter int LEVEL_COUNT  = spmf_pkg::LEVEL_COUNT_DEF,
    parameter int LEVEL_DEPTH  = spmf_pkg::LEVEL_DEPTH_DEF,
    parameter int HANDLE_WIDTH = spmf_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    spmf_stream_if.sink                cmd,
    spmf_stream_if.source              rsp,
    input  logic                       cfg_wr_en,
    input  logic [spmf_pkg::CFG_W-1:0] cfg_wr_data
);
    import spmf_pkg::*;

    localparam int LVL_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int TOT_W = $clog2(LEVEL_COUNT * LEVEL_DEPTH + 1);

    // ---------------------------------------------------------------- config
    logic [CFG_W-1:0] levels_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= LEVELS_RESET;
        end
        else if (cfg_wr_en)
        begin
            levels_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------ command register
    cmd_word_t cmd_reg;
    logic      cmd_valid_reg, cmd_valid_next;
    logic      cmd_take;
    logic      proc_fire;              // command register -> response register

    rsp_word_t rsp_reg, rsp_next;
    logic      rsp_valid_reg, rsp_valid_next;

    assign proc_fire = cmd_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready = !cmd_valid_reg || proc_fire;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (cmd_take)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg <= cmd.payload;
        end
    end

    // ---------------------------------------------------------------- levels
    lvl_ctrl_t               lvl_ctrl       [LEVEL_COUNT];
    lvl_stat_t               lvl_stat       [LEVEL_COUNT];
    logic [HANDLE_WIDTH-1:0] lvl_front      [LEVEL_COUNT];
    logic [HANDLE_WIDTH-1:0] lvl_front_next [LEVEL_COUNT];

    logic [LEVEL_COUNT-1:0]  nonempty_vec;
    logic [LEVEL_COUNT-1:0]  nonempty_next_vec;
    logic [LEVEL_COUNT-1:0]  full_vec;
    logic [LEVEL_COUNT-1:0]  push_vec;
    logic [LEVEL_COUNT-1:0]  pop_vec;
    logic [HANDLE_WIDTH-1:0] handle_in;

    assign handle_in = HANDLE_WIDTH'(cmd_reg.item);

    for (genvar g = 0; g < LEVEL_COUNT; g++)
    begin : g_level
        assign lvl_ctrl[g].push      = push_vec[g];
        assign lvl_ctrl[g].pop       = pop_vec[g];
        assign nonempty_vec[g]       = lvl_stat[g].nonempty;
        assign full_vec[g]           = lvl_stat[g].full;
        assign nonempty_next_vec[g]  = lvl_stat[g].nonempty_next;

        spmf_level_fifo #(
            .LEVEL_DEPTH  (LEVEL_DEPTH),
            .HANDLE_WIDTH (HANDLE_WIDTH)
        ) u_level (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (lvl_ctrl[g]),
            .push_data  (handle_in),
            .stat       (lvl_stat[g]),
            .front      (lvl_front[g]),
            .front_next (lvl_front_next[g])
        );
    end

    // highest set bit
    function automatic logic [LVL_W-1:0] top_of(input logic [LEVEL_COUNT-1:0] v);
        logic [LVL_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < LEVEL_COUNT; i++)
        begin
            if (v[i])
            begin
                idx = LVL_W'(i);
            end
        end
        return idx;
    endfunction

    // -------------------------------------------------------------- decode
    logic             range_err;
    logic [LVL_W-1:0] enq_lvl;
    logic [LVL_W-1:0] deq_lvl;
    logic [LVL_W-1:0] front_lvl;
    logic [TOT_W-1:0] total_reg, total_next;
    status_t          status_c;
    logic [ITEM_W-1:0] res_item_c;
    logic             res_valid_c;

    // out of range when at or above the register, or at or above the level count
    assign range_err = ({1'b0, cmd_reg.priority_req} >= levels_reg)
                    || (int'(cmd_reg.priority_req) >= LEVEL_COUNT);
    assign enq_lvl   = LVL_W'(cmd_reg.priority_req);
    assign deq_lvl   = top_of(nonempty_vec);

    always_comb
    begin
        push_vec    = '0;
        pop_vec     = '0;
        status_c    = ST_OK;
        res_item_c  = '0;
        res_valid_c = 1'b0;
        total_next  = total_reg;
        if (cmd_reg.func == FUNC_ENQ)
        begin
            if (range_err)
            begin
                status_c = ST_RANGE;
            end
            else if (full_vec[enq_lvl])
            begin
                status_c = ST_FULL;
            end
            else
            begin
                push_vec[enq_lvl] = proc_fire;
                total_next        = total_reg + 1'b1;
            end
        end
        else if (nonempty_vec == '0)
        begin
            status_c = ST_EMPTY;
        end
        else
        begin
            pop_vec[deq_lvl] = proc_fire;
            res_item_c       = ITEM_W'(lvl_front[deq_lvl]);
            res_valid_c      = 1'b1;
            total_next       = total_reg - 1'b1;
        end
    end

    // front after this command, from the levels' next state
    assign front_lvl = top_of(nonempty_next_vec);

    always_comb
    begin
        rsp_next.result_item  = res_item_c;
        rsp_next.result_valid = res_valid_c;
        rsp_next.status       = status_c;
        rsp_next.front_valid  = (nonempty_next_vec != '0);
        rsp_next.is_empty     = (nonempty_next_vec == '0);
        rsp_next.front_item   = (nonempty_next_vec != '0)
                              ? ITEM_W'(lvl_front_next[front_lvl]) : '0;
        rsp_next.item_count   = COUNT_W'(total_next);
    end

    // ----------------------------------------------------- response register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (proc_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (proc_fire)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    // ------------------------------------------------------------ assertions
    a_count_matches_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg == '0) == (nonempty_vec == '0))
        else $error("total count disagrees with level occupancy");

    a_one_level_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({push_vec, pop_vec}))
        else $error("more than one level push/pop in a cycle");

    a_empty_deq: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && (cmd_reg.func == FUNC_DEQ) && (nonempty_vec == '0)
        |=> (rsp_reg.status == ST_EMPTY) && rsp_reg.is_empty
            && !rsp_reg.result_valid)
        else $error("dequeue on empty queue reported wrongly");

    a_front_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.payload.front_valid != rsp.payload.is_empty))
        else $error("front_valid and is_empty disagree");

endmodule

// ===== rtl/spmf_level_fifo.sv =====
// ============================================================================
// spmf_level_fifo - one priority level's FIFO
// Memory with registered read, plus a front register and a prefetch of the
// entry behind the front so a pop can be followed by a pop every cycle.
// ============================================================================
module spmf_level_fifo #(
    parameter int LEVEL_DEPTH  = spmf_pkg::LEVEL_DEPTH_DEF,
    parameter int HANDLE_WIDTH = spmf_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  spmf_pkg::lvl_ctrl_t     ctrl,
    input  logic [HANDLE_WIDTH-1:0] push_data,
    output spmf_pkg::lvl_stat_t     stat,
    output logic [HANDLE_WIDTH-1:0] front,
    output logic [HANDLE_WIDTH-1:0] front_next
);
    import spmf_pkg::*;

    localparam int PTR_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(LEVEL_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LEVEL_DEPTH);

    logic [HANDLE_WIDTH-1:0] mem [LEVEL_DEPTH];

    logic [PTR_W-1:0]        head_reg, head_next;
    logic [PTR_W-1:0]        tail_reg, tail_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [HANDLE_WIDTH-1:0] front_reg;
    logic [HANDLE_WIDTH-1:0] pre_reg;     // entry one behind the front
    logic [PTR_W-1:0]        rd_addr;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        front_next = front_reg;
        if (ctrl.push)
        begin
            tail_next = ptr_inc(tail_reg);
            fill_next = fill_reg + 1'b1;
            if (fill_reg == '0)
            begin
                front_next = push_data;
            end
        end
        if (ctrl.pop)
        begin
            head_next  = ptr_inc(head_reg);
            fill_next  = fill_reg - 1'b1;
            front_next = pre_reg;
        end
        rd_addr = ptr_inc(head_next);
    end

    assign stat.nonempty      = (fill_reg != '0);
    assign stat.full          = (fill_reg == FILL_MAX);
    assign stat.nonempty_next = (fill_next != '0);
    assign front              = front_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // storage and prefetch; a write to the prefetch address is bypassed
    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_data;
        end
        if (ctrl.push && (tail_reg == rd_addr))
        begin
            pre_reg <= push_data;
        end
        else
        begin
            pre_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== tb/strict_priority_multi_fifo_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// strict_priority_multi_fifo_test - self-checking bench for the priority queue
// Drives command words over the cmd channel while a local queue model tracks
// every level, and checks each response word field by field in order.
// Directed tests cover the corner cases; random traffic with bursty input and
// a stalling receiver covers the rest.
// ============================================================================
module strict_priority_multi_fifo_test;

    import spmf_pkg::*;

    localparam int LEVEL_COUNT  = LEVEL_COUNT_DEF;
    localparam int LEVEL_DEPTH  = LEVEL_DEPTH_DEF;
    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYC   = 4;       // pipeline latency plus margin
    localparam int MAX_REPORTS  = 10;

    // receiver behavior, switched at random intervals
    typedef enum int
    {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SLOW
    } rx_mode_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    spmf_stream_if #(.payload_t(cmd_word_t)) cmd_if ();
    spmf_stream_if #(.payload_t(rsp_word_t)) rsp_if ();

    strict_priority_multi_fifo dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_if),
        .rsp         (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // Queue model: mirrors the per-level FIFOs of the block
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]  levels_in_use;
    logic [ITEM_W-1:0] slot_item [LEVEL_COUNT][LEVEL_DEPTH];
    int                head_pos  [LEVEL_COUNT];
    int                tail_pos  [LEVEL_COUNT];
    int                level_fill[LEVEL_COUNT];
    int                total_fill;

    rsp_word_t expected_rsp_q[$];

    int  mismatch_count;
    int  cycle_count;
    int  burst_left;
    bit  pace_bursts;
    int  rsp_hold_left;    // receiver hold-off request, counted down by the receiver

    // register value above LEVEL_COUNT saturates
    function automatic int active_levels();
        return (levels_in_use > LEVEL_COUNT) ? LEVEL_COUNT : int'(levels_in_use);
    endfunction

    // highest level holding an item, -1 when all are empty
    function automatic int highest_nonempty();
        for (int lv = LEVEL_COUNT - 1; lv >= 0; lv--)
        begin
            if (level_fill[lv] != 0)
                return lv;
        end
        return -1;
    endfunction

    // Applies one command to the model and returns the response word it owes.
    // Rejected commands (range, full, empty) leave the model untouched.
    function automatic rsp_word_t predict_response(input cmd_word_t c);
        rsp_word_t r;
        int        lv;
        r = '0;
        r.status = ST_OK;
        if (c.func == FUNC_ENQ)
        begin
            lv = int'(c.priority_req);
            if (lv >= active_levels())
                r.status = ST_RANGE;        // range wins over full
            else if (level_fill[lv] >= LEVEL_DEPTH)
                r.status = ST_FULL;
            else
            begin
                slot_item[lv][tail_pos[lv]] = c.item;
                tail_pos[lv] = (tail_pos[lv] + 1) % LEVEL_DEPTH;
                level_fill[lv]++;
                total_fill++;
            end
        end
        else
        begin
            // dequeue looks at every level, even above levels_in_use
            lv = highest_nonempty();
            if (lv < 0)
                r.status = ST_EMPTY;
            else
            begin
                r.result_item  = slot_item[lv][head_pos[lv]];
                r.result_valid = 1'b1;
                head_pos[lv] = (head_pos[lv] + 1) % LEVEL_DEPTH;
                level_fill[lv]--;
                total_fill--;
            end
        end
        lv = highest_nonempty();
        if (lv >= 0)
        begin
            r.front_item  = slot_item[lv][head_pos[lv]];
            r.front_valid = 1'b1;
        end
        r.is_empty   = (lv < 0);
        r.item_count = COUNT_W'(total_fill);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stalls on a mode that is redrawn at random intervals; a
    // hold-off request from a test overrides the mode until it is counted down.
    // ------------------------------------------------------------------------
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       tick;
        mode      = RX_ALWAYS;
        mode_left = 0;
        tick      = 0;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            tick++;
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (rsp_hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                rsp_hold_left--;
            end
            else
            begin
                case (mode)
                    RX_ALWAYS:  rsp_if.ready <= 1'b1;
                    RX_RANDOM:  rsp_if.ready <= ($urandom_range(0, 99) < 70);
                    RX_PATTERN: rsp_if.ready <= (tick % 5 != 0) && (tick % 7 != 3);
                    default:    rsp_if.ready <= ($urandom_range(0, 99) < 25);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response checker
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string field, input logic [ITEM_W-1:0] want,
                                 input logic [ITEM_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : check_rsp
        rsp_word_t want;
        rsp_word_t got;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            got = rsp_if.payload;
            if (expected_rsp_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] response word with none expected: %0h", $time, got);
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (got.result_item !== want.result_item)
                    note_mismatch("result_item", want.result_item, got.result_item);
                if (got.result_valid !== want.result_valid)
                    note_mismatch("result_valid", want.result_valid, got.result_valid);
                if (got.status !== want.status)
                    note_mismatch("status", want.status, got.status);
                if (got.front_item !== want.front_item)
                    note_mismatch("front_item", want.front_item, got.front_item);
                if (got.front_valid !== want.front_valid)
                    note_mismatch("front_valid", want.front_valid, got.front_valid);
                if (got.is_empty !== want.is_empty)
                    note_mismatch("is_empty", want.is_empty, got.is_empty);
                if (got.item_count !== want.item_count)
                    note_mismatch("item_count", want.item_count, got.item_count);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offers one command word; with pacing on the sender runs in bursts with
    // idle gaps in between. valid stays high between back-to-back words.
    task automatic send_cmd(input cmd_word_t w);
        int gap;
        if (pace_bursts)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
                @(negedge clk);
                cmd_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left--;
        end
        @(negedge clk);
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= w;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        expected_rsp_q.push_back(predict_response(w));
    endtask

    task automatic send_enq(input logic [PRIO_W-1:0] prio, input logic [ITEM_W-1:0] item);
        cmd_word_t w;
        w.func         = FUNC_ENQ;
        w.item         = item;
        w.priority_req = prio;
        send_cmd(w);
    endtask

    // dequeue carries random junk in the ignored fields
    task automatic send_deq();
        cmd_word_t w;
        w.func         = FUNC_DEQ;
        w.item         = $urandom;
        w.priority_req = PRIO_W'($urandom_range(0, 7));
        send_cmd(w);
    endtask

    // drop valid and wait until every response word is back
    task automatic wait_drained();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // block is idle whenever this is called
    task automatic write_levels(input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        levels_in_use = v;
    endtask

    // Mostly legal priorities; some noise anywhere in the field
    function automatic cmd_word_t random_cmd(input int enq_pct);
        cmd_word_t w;
        int        lv_top;
        lv_top = active_levels();
        w.func = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
        w.item = $urandom;
        if (lv_top > 0 && $urandom_range(0, 99) < 85)
            w.priority_req = PRIO_W'($urandom_range(0, lv_top - 1));
        else
            w.priority_req = PRIO_W'($urandom_range(0, 7));
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_empty_dequeue();
        send_deq();
    endtask

    // levels served high first, FIFO order inside a level, extreme handles
    task automatic test_priority_order();
        send_enq(3'd0, 32'h0000_0000);
        send_enq(3'd7, 32'hFFFF_FFFF);
        send_enq(3'd7, 32'h5555_5555);
        send_enq(3'd3, 32'hAAAA_AAAA);
        repeat (5) send_deq();     // last one hits an empty queue
    endtask

    // fill one level, overflow it, then lower the register past it: range
    // check must win and the held items must stay reachable
    task automatic test_level_full();
        repeat (LEVEL_DEPTH) send_enq(3'd5, $urandom);
        send_enq(3'd5, $urandom);
        wait_drained();
        write_levels(4'd2);
        send_enq(3'd5, $urandom);
        send_deq();
        send_enq(3'd7, $urandom);
        send_enq(3'd1, $urandom);
        wait_drained();
    endtask

    // register extremes: zero rejects all, above max saturates, one level only
    task automatic test_levels_extremes();
        write_levels(4'd0);
        send_enq(3'd0, $urandom);
        wait_drained();
        write_levels(4'd15);
        send_enq(3'd7, $urandom);
        wait_drained();
        write_levels(4'd1);
        send_enq(3'd1, $urandom);
        send_enq(3'd0, $urandom);
        wait_drained();
        write_levels(4'd8);
    endtask

    // receiver holds off long while the sender keeps pushing back to back,
    // so the pipeline fills and cmd.ready drops
    task automatic test_backpressure();
        pace_bursts   = 1'b0;
        rsp_hold_left = 150;
        repeat (40) send_cmd(random_cmd(60));
        pace_bursts   = 1'b1;
        wait_drained();
    endtask

    // sender goes quiet until every response word is home, then resumes
    task automatic test_sender_pause();
        repeat (20) send_cmd(random_cmd(70));
        wait_drained();
        repeat (20) send_cmd(random_cmd(30));
        wait_drained();
    endtask

    // one register setting; the mix swings between filling and draining so
    // full levels and the empty queue both come up
    task automatic run_traffic_phase(input int n_words, input logic [CFG_W-1:0] lv);
        int enq_pct;
        wait_drained();
        write_levels(lv);
        enq_pct = 80;
        for (int i = 0; i < n_words; i++)
        begin
            if (i % 40 == 0)
                enq_pct = (enq_pct == 80) ? 25 : 80;
            send_cmd(random_cmd(enq_pct));
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(600, 4'd8);
        run_traffic_phase(300, 4'd3);
        run_traffic_phase(300, 4'd15);
        run_traffic_phase(200, 4'd1);
        run_traffic_phase(250, 4'd5);
        run_traffic_phase(50,  4'd0);
        run_traffic_phase(250, 4'd8);
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        rst_n          = 1'b0;
        mismatch_count = 0;
        burst_left     = 0;
        pace_bursts    = 1'b1;
        rsp_hold_left  = 0;
        levels_in_use  = LEVELS_RESET;
        total_fill     = 0;
        for (int lv = 0; lv < LEVEL_COUNT; lv++)
        begin
            head_pos[lv]   = 0;
            tail_pos[lv]   = 0;
            level_fill[lv] = 0;
        end

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_empty_dequeue();
        test_priority_order();
        test_level_full();
        test_levels_extremes();
        test_backpressure();
        test_sender_pause();
        test_random_traffic();

        if (mismatch_count == 0 && expected_rsp_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spmf_pkg.sv
rtl/spmf_stream_if.sv
rtl/spmf_level_fifo.sv
rtl/strict_priority_multi_fifo.sv
tb/strict_priority_multi_fifo_test.sv
